// ===== sv/pin_bbox_wirelength_core_macros.svh =====
// Assertion macros for the pin bounding-box wirelength core.
// Included by the top level; no other dependencies.
`ifndef PIN_BBOX_WIRELENGTH_CORE_MACROS_SVH
`define PIN_BBOX_WIRELENGTH_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PBW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PBW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/pbw_pkg.sv =====
// Shared types and constants of the pin bounding-box wirelength core.
// No dependencies; imported by every other file but the macros header.
`timescale 1ns / 1ps
`default_nettype none

package pbw_pkg;

   // Field widths of the pin and result transfers
   localparam int CENTER_W   = 31;
   localparam int OFFSET_W   = 17;
   localparam int ORIENT_W   = 3;
   localparam int NET_WL_W   = 33;
   localparam int TOTAL_OUT_W = 48;

   // Default datapath widths
   localparam int COORD_BITS_DEF = 32;
   localparam int TOTAL_BITS_DEF = 48;

   // Pin count: saturates once a net has enough pins for a box
   localparam logic [1:0] PINS_NONE   = 2'd0;
   localparam logic [1:0] PINS_ENOUGH = 2'd2;

   // Cell orientations
   typedef enum logic [ORIENT_W-1:0] {
      ORIENT_R0    = 3'd0,
      ORIENT_R90   = 3'd1,
      ORIENT_R180  = 3'd2,
      ORIENT_R270  = 3'd3,
      ORIENT_MY    = 3'd4,
      ORIENT_MYR90 = 3'd5,
      ORIENT_MX    = 3'd6,
      ORIENT_MXR90 = 3'd7
   } orient_type;

   // Per-pin control flags carried along with the pin point
   typedef struct packed {
      logic last_pin;
      logic new_list;
   } pin_flags_type;

   // One result transfer
   typedef struct packed {
      logic [NET_WL_W-1:0]    net_wirelength;
      logic [TOTAL_OUT_W-1:0] total_wirelength;
      logic                   too_few_pins;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/pbw_req_if.sv =====
// Pin input channel: valid/ready plus one pin's fields.
// Depends on pbw_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pbw_req_if import pbw_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [CENTER_W-1:0] center_x;
   logic signed [CENTER_W-1:0] center_y;
   logic signed [OFFSET_W-1:0] offset_x;
   logic signed [OFFSET_W-1:0] offset_y;
   logic [ORIENT_W-1:0]        orientation;
   logic                       last_pin;
   logic                       new_list;

   modport source (
      output valid, center_x, center_y, offset_x, offset_y, orientation,
             last_pin, new_list,
      input  ready
   );

   modport sink (
      input  valid, center_x, center_y, offset_x, offset_y, orientation,
             last_pin, new_list,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/pbw_rsp_if.sv =====
// Result channel: valid/ready plus one net's wirelength result.
// Depends on pbw_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pbw_rsp_if import pbw_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [NET_WL_W-1:0]    net_wirelength;
   logic [TOTAL_OUT_W-1:0] total_wirelength;
   logic                   too_few_pins;

   modport source (
      output valid, net_wirelength, total_wirelength, too_few_pins,
      input  ready
   );

   modport sink (
      input  valid, net_wirelength, total_wirelength, too_few_pins,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/pin_bbox_wirelength_core.sv =====
// Top level of the pin bounding-box wirelength core.
// Depends on pbw_pkg, pbw_req_if, pbw_rsp_if, pbw_pin_stage, pbw_net_accum
// and pin_bbox_wirelength_core_macros.svh.
//
// Usage:
//   req_chan carries one pin per transfer: cell center, pin offset,
//   orientation, and the last_pin / new_list flags. Pins of a net arrive
//   in order; the transfer with last_pin set closes the net.
//   rsp_chan carries one result per closed net: half-perimeter wirelength
//   (saturated to 33 bits), the saturating running total and a flag for
//   nets with fewer than two pins (wirelength 0, nothing added to total).
//   Path: the point register loads at the last pin's transfer, and the
//   result register loads from it when that pin moves on; a stalled
//   receiver can hold the pin in the point register between the two.
//   Throughput: one pin per cycle while no last pin waits on a stalled
//   receiver; box compare, span add and total add feed the result register.
//   Reset (synchronous) empties both stages, clears the pin count and the
//   running total; the box is reloaded by the next pin.
//   When the receiver stalls, the result register holds; pins that do
//   not close a net keep flowing, and a last pin waits in the point
//   register, which then drops req_chan.ready.
`timescale 1ns / 1ps
`default_nettype none
`include "pin_bbox_wirelength_core_macros.svh"

module pin_bbox_wirelength_core import pbw_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   pbw_req_if.sink   req_chan,
   pbw_rsp_if.source rsp_chan
);

   pin_flags_type                in_flags, pt_flags;
   logic                         pt_valid, pt_ready;
   logic signed [COORD_BITS-1:0] point_x, point_y;
   logic                         res_valid;
   result_type                   result;

   assign in_flags.last_pin = req_chan.last_pin;
   assign in_flags.new_list = req_chan.new_list;

   // Pin point formation and input register
   pbw_pin_stage #(
      .COORD_BITS (COORD_BITS)
   ) u_pin_stage (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .center_x    (req_chan.center_x),
      .center_y    (req_chan.center_y),
      .offset_x    (req_chan.offset_x),
      .offset_y    (req_chan.offset_y),
      .orientation (req_chan.orientation),
      .in_flags    (in_flags),
      .out_valid   (pt_valid),
      .out_ready   (pt_ready),
      .point_x     (point_x),
      .point_y     (point_y),
      .out_flags   (pt_flags)
   );

   // Bounding box, totals and result register
   pbw_net_accum #(
      .COORD_BITS (COORD_BITS),
      .TOTAL_BITS (TOTAL_BITS)
   ) u_net_accum (
      .clock     (clock),
      .reset     (reset),
      .pt_valid  (pt_valid),
      .pt_ready  (pt_ready),
      .point_x   (point_x),
      .point_y   (point_y),
      .pt_flags  (pt_flags),
      .res_valid (res_valid),
      .res_ready (rsp_chan.ready),
      .result    (result)
   );

   assign rsp_chan.valid            = res_valid;
   assign rsp_chan.net_wirelength   = result.net_wirelength;
   assign rsp_chan.total_wirelength = result.total_wirelength;
   assign rsp_chan.too_few_pins     = result.too_few_pins;

   // Checks
   `PBW_ASSERT_IMPLY(a_short_net_zero, clock, reset,
      rsp_chan.valid && rsp_chan.too_few_pins, rsp_chan.net_wirelength == '0,
      "short net reported a nonzero wirelength")
   `PBW_ASSERT_IMPLY(a_stall_means_full, clock, reset,
      !req_chan.ready, pt_valid && pt_flags.last_pin && rsp_chan.valid,
      "pin input stalled without a blocked last pin")
   `PBW_ASSERT_NEXT(a_last_pin_waits, clock, reset,
      pt_valid && pt_flags.last_pin && rsp_chan.valid && !rsp_chan.ready,
      pt_valid && pt_flags.last_pin,
      "blocked last pin left the point register")

endmodule

`default_nettype wire

// ===== sv/pbw_pin_stage.sv =====
// Pin point stage: applies the orientation to the offset, adds the cell
// center and registers the point with its flags. Depends on pbw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbw_pin_stage import pbw_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // upstream
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic signed [CENTER_W-1:0]   center_x,
   input  wire logic signed [CENTER_W-1:0]   center_y,
   input  wire logic signed [OFFSET_W-1:0]   offset_x,
   input  wire logic signed [OFFSET_W-1:0]   offset_y,
   input  wire logic [ORIENT_W-1:0]          orientation,
   input  wire pin_flags_type                in_flags,
   // downstream
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic signed [COORD_BITS-1:0]      point_x,
   output logic signed [COORD_BITS-1:0]      point_y,
   output pin_flags_type                     out_flags
);

   localparam int NEG_W = OFFSET_W + 1;
   localparam int SUM_W = CENTER_W + 2;

   logic signed [NEG_W-1:0] ox_pos, ox_neg, oy_pos, oy_neg;
   logic signed [NEG_W-1:0] dx, dy;
   logic signed [SUM_W-1:0] sum_x, sum_y;
   orient_type              orient;

   logic                          valid_ff, valid_in;
   logic signed [COORD_BITS-1:0]  x_ff, y_ff;
   pin_flags_type                 flags_ff;

   // Offset rotation / mirror; negation needs one extra bit
   always_comb begin
      ox_pos = NEG_W'(offset_x);
      oy_pos = NEG_W'(offset_y);
      ox_neg = -ox_pos;
      oy_neg = -oy_pos;
      orient = orient_type'(orientation);
      unique case (orient)
         ORIENT_R0:    begin dx = ox_pos; dy = oy_pos; end
         ORIENT_R90:   begin dx = oy_pos; dy = ox_neg; end
         ORIENT_R180:  begin dx = ox_neg; dy = oy_neg; end
         ORIENT_R270:  begin dx = oy_neg; dy = ox_pos; end
         ORIENT_MY:    begin dx = ox_neg; dy = oy_pos; end
         ORIENT_MYR90: begin dx = oy_pos; dy = ox_pos; end
         ORIENT_MX:    begin dx = ox_pos; dy = oy_neg; end
         ORIENT_MXR90: begin dx = oy_neg; dy = ox_neg; end
         default:      begin dx = ox_pos; dy = oy_pos; end
      endcase
      sum_x = SUM_W'(center_x) + SUM_W'(dx);
      sum_y = SUM_W'(center_y) + SUM_W'(dy);
   end

   // Stage handshake: take a pin when empty or when the held one moves on
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Point wraps or sign-extends to the coordinate width
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff     <= COORD_BITS'(sum_x);
         y_ff     <= COORD_BITS'(sum_y);
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign point_x   = x_ff;
   assign point_y   = y_ff;
   assign out_flags = flags_ff;

endmodule

`default_nettype wire

// ===== sv/pbw_net_accum.sv =====
// Net accumulator: bounding box, pin count, saturating total and the
// result register. Depends on pbw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbw_net_accum import pbw_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // pin points
   input  wire logic                         pt_valid,
   output logic                              pt_ready,
   input  wire logic signed [COORD_BITS-1:0] point_x,
   input  wire logic signed [COORD_BITS-1:0] point_y,
   input  wire pin_flags_type                pt_flags,
   // results
   output logic                              res_valid,
   input  wire logic                         res_ready,
   output result_type                        result
);

   localparam int WL_W  = COORD_BITS + 1;
   localparam int EXT_W = (WL_W > NET_WL_W) ? WL_W : NET_WL_W + 1;
   localparam int SUM_W = ((TOTAL_BITS > WL_W) ? TOTAL_BITS : WL_W) + 1;

   logic signed [COORD_BITS-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic signed [COORD_BITS-1:0] min_x_in, max_x_in, min_y_in, max_y_in;
   logic [1:0]                   pins_ff, pins_in;
   logic [TOTAL_BITS-1:0]        total_ff, total_in, total_base, total_add;
   logic                         res_valid_ff, res_valid_in;
   result_type                   result_ff, result_in;

   logic                  first_pin, pt_fire, out_room;
   logic [COORD_BITS-1:0] span_x, span_y;
   logic [WL_W-1:0]       wl;
   logic [EXT_W-1:0]      wl_ext;
   logic [NET_WL_W-1:0]   net_out;
   logic [SUM_W-1:0]      sum;

   // Non-last pins never need the result register
   assign out_room = !res_valid_ff || res_ready;
   assign pt_ready = !pt_flags.last_pin || out_room;
   assign pt_fire  = pt_valid && pt_ready;

   // Box update: first pin of a net loads, later pins extend
   always_comb begin
      first_pin = (pins_ff == PINS_NONE);
      if (first_pin) begin
         min_x_in = point_x;
         max_x_in = point_x;
         min_y_in = point_y;
         max_y_in = point_y;
      end else begin
         min_x_in = (point_x < min_x_ff) ? point_x : min_x_ff;
         max_x_in = (point_x > max_x_ff) ? point_x : max_x_ff;
         min_y_in = (point_y < min_y_ff) ? point_y : min_y_ff;
         max_y_in = (point_y > max_y_ff) ? point_y : max_y_ff;
      end
   end

   // Half perimeter of the updated box, saturated to the output width
   always_comb begin
      span_x  = max_x_in - min_x_in;
      span_y  = max_y_in - min_y_in;
      wl      = WL_W'(span_x) + WL_W'(span_y);
      wl_ext  = EXT_W'(wl);
      net_out = (|wl_ext[EXT_W-1:NET_WL_W]) ? '1 : wl_ext[NET_WL_W-1:0];
   end

   // Saturating total; a new list starts from zero before this pin
   always_comb begin
      total_base = pt_flags.new_list ? '0 : total_ff;
      sum        = SUM_W'(total_base) + SUM_W'(wl);
      total_add  = (|sum[SUM_W-1:TOTAL_BITS]) ? '1 : sum[TOTAL_BITS-1:0];
   end

   // Next state and result
   always_comb begin
      pins_in      = pins_ff;
      total_in     = total_ff;
      res_valid_in = res_valid_ff && !res_ready;
      result_in    = result_ff;
      if (pt_fire) begin
         total_in = total_base;
         if (pins_ff != PINS_ENOUGH) begin
            pins_in = pins_ff + 2'd1;
         end
         if (pt_flags.last_pin) begin
            pins_in      = PINS_NONE;
            res_valid_in = 1'b1;
            if (first_pin) begin
               // single-pin net: nothing added, total still reported
               result_in.net_wirelength   = '0;
               result_in.total_wirelength = TOTAL_OUT_W'(total_base);
               result_in.too_few_pins     = 1'b1;
            end else begin
               total_in                   = total_add;
               result_in.net_wirelength   = net_out;
               result_in.total_wirelength = TOTAL_OUT_W'(total_add);
               result_in.too_few_pins     = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pins_ff      <= PINS_NONE;
         total_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         pins_ff      <= pins_in;
         total_ff     <= total_in;
         res_valid_ff <= res_valid_in;
      end
   end

   // Box contents only matter once the first pin of a net has loaded them
   always_ff @(posedge clock) begin
      if (pt_fire) begin
         min_x_ff <= min_x_in;
         max_x_ff <= max_x_in;
         min_y_ff <= min_y_in;
         max_y_ff <= max_y_in;
      end
      result_ff <= result_in;
   end

   assign res_valid = res_valid_ff;
   assign result    = result_ff;

endmodule

`default_nettype wire
